@@ sv/kto_pkg.sv @@
// Shared types, widths and codes for the keyed timeout table.
package kto_pkg;

    localparam int DEPTH      = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KEY_W      = 32;
    localparam int DLY_W      = 14;
    localparam int IN_DLY_W   = 16;
    localparam int ELAPSED_W  = 16;
    localparam int STATUS_W   = 3;
    localparam int OPC_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 64;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 1'd1;

    localparam logic [DLY_W-1:0] MIN_DELAY_RST = 14'd2000;
    localparam logic [DLY_W-1:0] MAX_DELAY_RST = 14'd10000;

    typedef enum logic [OPC_W-1:0] {
        OPC_ARM    = 2'd0,
        OPC_DISARM = 2'd1,
        OPC_TICK   = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 3'd0,
        ST_REFRESH = 3'd1,
        ST_IGNORED = 3'd2,
        ST_FULL    = 3'd3,
        ST_DISARM  = 3'd4,
        ST_EXPIRED = 3'd5,
        ST_NONE    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CK_ARM,
        CK_IGNORE,
        CK_DISARM,
        CK_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [KEY_W-1:0]       owner;
        logic [KEY_W-1:0]       item;
        logic [DLY_W-1:0]       delay;    // already clamped
        logic [ELAPSED_W-1:0]   elapsed;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

endpackage

@@ sv/kto_front.sv @@
// Front end: takes input items, holds the delay limits, classifies and clamps.
module kto_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kto_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [kto_pkg::OPC_W-1:0]       s_tuser,
    input  logic                            cfg_we,
    input  logic [kto_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kto_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            push,
    output kto_pkg::cmd_t                   cmd,
    input  logic                            full
);
    import kto_pkg::*;

    logic [DLY_W-1:0]     min_delay_reg;
    logic [DLY_W-1:0]     max_delay_reg;
    logic [KEY_W-1:0]     owner;
    logic [KEY_W-1:0]     item;
    logic [IN_DLY_W-1:0]  delay_in;
    logic [IN_DLY_W-1:0]  delay_lo;
    logic [IN_DLY_W-1:0]  min_ext;
    logic [IN_DLY_W-1:0]  max_ext;
    logic                 item_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg <= MIN_DELAY_RST;
            max_delay_reg <= MAX_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DELAY: min_delay_reg <= cfg_data;
                REG_MAX_DELAY: max_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign owner    = s_tdata[31:0];
    assign item     = s_tdata[63:32];
    assign delay_in = s_tdata[79:64];
    assign min_ext  = {{(IN_DLY_W-DLY_W){1'b0}}, min_delay_reg};
    assign max_ext  = {{(IN_DLY_W-DLY_W){1'b0}}, max_delay_reg};
    assign item_pos = !item[KEY_W-1] && (item != '0);

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    always_comb
    begin
        // raise to min first, then max wins if the limits cross
        delay_lo = (delay_in < min_ext) ? min_ext : delay_in;
        cmd.owner   = owner;
        cmd.item    = item;
        cmd.elapsed = s_tdata[95:80];
        cmd.delay   = (delay_lo > max_ext) ? max_delay_reg : delay_lo[DLY_W-1:0];
        case (opcode_t'(s_tuser))
            OPC_ARM:    cmd.kind = item_pos ? CK_ARM : CK_IGNORE;
            OPC_DISARM: cmd.kind = CK_DISARM;
            OPC_TICK:   cmd.kind = CK_TICK;
            default:    cmd.kind = CK_IGNORE;
        endcase
    end

endmodule

@@ sv/kto_queue.sv @@
// Two-entry command queue between the front end and the table engine.
module kto_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kto_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output kto_pkg::cmd_t  head_cmd,
    output logic           empty
);
    import kto_pkg::*;

    cmd_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  fill_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (fill_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/kto_back.sv @@
// Table engine: keyed timer entries, parallel key match, tick scan, result register.
module kto_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kto_pkg::cmd_t                  cmd,
    input  logic                           q_empty,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kto_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [kto_pkg::STATUS_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import kto_pkg::*;

    // table storage, kept in insertion order at positions below count_reg
    logic [KEY_W-1:0]      owner_reg  [DEPTH];
    logic [KEY_W-1:0]      item_reg   [DEPTH];
    logic [DLY_W-1:0]      rem_reg    [DEPTH];
    logic [KEY_W-1:0]      owner_next [DEPTH];
    logic [KEY_W-1:0]      item_next  [DEPTH];
    logic [DLY_W-1:0]      rem_next   [DEPTH];
    logic [KEY_W-1:0]      owner_sh   [DEPTH];
    logic [KEY_W-1:0]      item_sh    [DEPTH];
    logic [DLY_W-1:0]      rem_sh     [DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [CNT_W-1:0]      scan_left_reg;
    logic [CNT_W-1:0]      exp_left_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [KEY_W-1:0]      out_owner_reg;
    logic [KEY_W-1:0]      out_item_reg;
    logic                  out_last_reg;

    logic [DEPTH-1:0]      valid_vec;
    logic [DEPTH-1:0]      match;
    logic [DEPTH-1:0]      first;
    logic [DEPTH-1:0]      above;
    logic [DEPTH-1:0]      exp_vec;
    logic                  hit;
    logic [CNT_W-1:0]      nexp;
    logic                  head_exp;
    logic                  can_load;
    logic [CNT_W-1:0]      tail_pos;

    logic                  emit;
    status_t               emit_status;
    logic [KEY_W-1:0]      emit_owner;
    logic [KEY_W-1:0]      emit_item;
    logic                  emit_last;
    logic                  do_append;
    logic                  do_refresh;
    logic                  do_remove;
    logic                  do_sub_all;
    logic                  do_start;
    logic                  do_step;
    logic                  step_exp;

    assign can_load = !out_valid_reg || m_tready;
    assign tail_pos = count_reg - 1'b1;
    assign head_exp = ({{(ELAPSED_W-DLY_W){1'b0}}, rem_reg[0]} <= elapsed_reg);

    // parallel key compare and expiry test over all live entries
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = (CNT_W'(i) < count_reg);
            match[i]     = valid_vec[i] && (owner_reg[i] == cmd.owner)
                           && (item_reg[i] == cmd.item);
            exp_vec[i]   = valid_vec[i]
                           && ({{(ELAPSED_W-DLY_W){1'b0}}, rem_reg[i]} <= cmd.elapsed);
        end
        hit   = |match;
        first = match & (~match + DEPTH'(1));
        above = hit ? ~(first - DEPTH'(1)) : '0;
        nexp  = CNT_W'($countones(exp_vec));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && can_load && (cmd.kind == CK_TICK) && (nexp != '0))
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if ((scan_left_reg == CNT_W'(1)) && (!head_exp || can_load))
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        emit        = 1'b0;
        emit_status = ST_NONE;
        emit_owner  = '0;
        emit_item   = '0;
        emit_last   = 1'b1;
        do_append   = 1'b0;
        do_refresh  = 1'b0;
        do_remove   = 1'b0;
        do_sub_all  = 1'b0;
        do_start    = 1'b0;
        do_step     = 1'b0;
        step_exp    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && can_load)
                begin
                    pop  = 1'b1;
                    emit = 1'b1;
                    case (cmd.kind)
                        CK_ARM:
                        begin
                            if (hit)
                            begin
                                do_refresh  = 1'b1;
                                emit_status = ST_REFRESH;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                do_append   = 1'b1;
                                emit_status = ST_NEW;
                            end
                        end
                        CK_DISARM:
                        begin
                            do_remove   = hit;
                            emit_status = ST_DISARM;
                        end
                        CK_TICK:
                        begin
                            if (nexp == '0)
                            begin
                                do_sub_all  = 1'b1;
                                emit_status = ST_NONE;
                            end
                            else
                            begin
                                emit     = 1'b0;
                                do_start = 1'b1;
                            end
                        end
                        default: emit_status = ST_IGNORED;
                    endcase
                end
            end
            BK_SCAN:
            begin
                // head is always the oldest unvisited entry; survivors rotate to the tail
                if (head_exp)
                begin
                    if (can_load)
                    begin
                        do_step     = 1'b1;
                        step_exp    = 1'b1;
                        emit        = 1'b1;
                        emit_status = ST_EXPIRED;
                        emit_owner  = owner_reg[0];
                        emit_item   = item_reg[0];
                        emit_last   = (exp_left_reg == CNT_W'(1));
                    end
                end
                else
                begin
                    do_step = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            owner_sh[i] = owner_reg[i+1];
            item_sh[i]  = item_reg[i+1];
            rem_sh[i]   = rem_reg[i+1];
        end
        owner_sh[DEPTH-1] = owner_reg[DEPTH-1];
        item_sh[DEPTH-1]  = item_reg[DEPTH-1];
        rem_sh[DEPTH-1]   = rem_reg[DEPTH-1];

        for (int i = 0; i < DEPTH; i++)
        begin
            owner_next[i] = owner_reg[i];
            item_next[i]  = item_reg[i];
            rem_next[i]   = rem_reg[i];
            if (do_append && (CNT_W'(i) == count_reg))
            begin
                owner_next[i] = cmd.owner;
                item_next[i]  = cmd.item;
                rem_next[i]   = cmd.delay;
            end
            if (do_refresh && first[i])
            begin
                rem_next[i] = cmd.delay;
            end
            if (do_remove && above[i])
            begin
                owner_next[i] = owner_sh[i];
                item_next[i]  = item_sh[i];
                rem_next[i]   = rem_sh[i];
            end
            // no entry expires here, so elapsed is below every remaining time
            if (do_sub_all && valid_vec[i])
            begin
                rem_next[i] = rem_reg[i] - DLY_W'(cmd.elapsed);
            end
            if (do_step)
            begin
                owner_next[i] = owner_sh[i];
                item_next[i]  = item_sh[i];
                rem_next[i]   = rem_sh[i];
                if (!step_exp && (CNT_W'(i) == tail_pos))
                begin
                    owner_next[i] = owner_reg[0];
                    item_next[i]  = item_reg[0];
                    rem_next[i]   = rem_reg[0] - DLY_W'(elapsed_reg);
                end
            end
        end

        count_next = count_reg;
        if (do_append)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_remove || step_exp)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            owner_reg[i] <= owner_next[i];
            item_reg[i]  <= item_next[i];
            rem_reg[i]   <= rem_next[i];
        end
        if (do_start)
        begin
            elapsed_reg <= cmd.elapsed;
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_owner_reg  <= emit_owner;
            out_item_reg   <= emit_item;
            out_last_reg   <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            scan_left_reg <= '0;
            exp_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (do_start)
            begin
                scan_left_reg <= count_reg;
                exp_left_reg  <= nexp;
            end
            else if (do_step)
            begin
                scan_left_reg <= scan_left_reg - 1'b1;
                if (step_exp)
                begin
                    exp_left_reg <= exp_left_reg - 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_item_reg, out_owner_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_scan_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |-> (scan_left_reg != '0) && (exp_left_reg <= scan_left_reg))
        else $error("scan counters inconsistent");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) && (state_next == BK_IDLE) |=> (exp_left_reg == '0))
        else $error("tick scan ended with expiries still owed");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> (exp_left_reg == '0))
        else $error("expiry count left over outside a scan");
`endif

endmodule

@@ sv/keyed_timeout_table_core.sv @@
// Top level of the keyed timeout table: front end, command queue, table engine.
//
//  port group     dir  contents
//  s_t*           in   tuser: opcode[1:0]; tdata: owner, item, delay, elapsed
//  m_t*           out  tuser: status[2:0]; tdata: expired owner, item; tlast
//  cfg_*          in   write enable, register index, 14-bit value
//
// Arm, disarm and ignored items are handled in the idle state of the table engine.
// A tick with no expiry lowers every remaining time; otherwise the scan visits
// one entry per cycle through the head position unless an expiry waits on m_tready.
// The two-entry queue keeps taking input items during a scan until it is full.
// Reset clears the entry count and delay limits to 2000/10000 ms; no clearing pass.
// Any cycle that loads a result waits on m_tready while the result register is
// still full; rotating a surviving entry during a scan never waits.
module keyed_timeout_table_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] owner_id, [63:32] item_id, [79:64] delay_ms, [95:80] elapsed_ms
    input  logic [kto_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [kto_pkg::OPC_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] expired_owner, [63:32] expired_item
    output logic [kto_pkg::M_TDATA_W-1:0]   m_tdata,
    // [2:0] status
    output logic [kto_pkg::STATUS_W-1:0]    m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [kto_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kto_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kto_pkg::*;

    logic  push;
    cmd_t  push_cmd;
    logic  q_full;
    logic  pop;
    cmd_t  head_cmd;
    logic  q_empty;

    kto_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (push_cmd),
        .full      (q_full)
    );

    kto_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    kto_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
